>>> sv/encoder_steering_angle_servo_top_assert.svh
// Assertion macros for the steering servo top.
// With SYNTH defined the macros expand to nothing.
`ifndef ENCODER_STEERING_ANGLE_SERVO_TOP_ASSERT_SVH
`define ENCODER_STEERING_ANGLE_SERVO_TOP_ASSERT_SVH

`ifndef SYNTH
// Condition a at a clock edge implies condition b at the same edge.
`define ESAS_ASSERT_SAME(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("steering servo assertion failed");
// Condition a at a clock edge implies condition b at the next edge.
`define ESAS_ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("steering servo assertion failed");
`else
`define ESAS_ASSERT_SAME(label, clk, rst_n, a, b)
`define ESAS_ASSERT_NEXT(label, clk, rst_n, a, b)
`endif

`endif

>>> sv/esas_pkg.sv
package esas_pkg;

    // Field widths
    localparam int POS_W   = 32;
    localparam int STEPS_W = 16;
    localparam int TOL_W   = 8;
    localparam int ANG_W   = 9;
    localparam int PROD_W  = STEPS_W + ANG_W;
    localparam int CNT_W   = 6;
    localparam int ADDR_W  = 3;

    // Degrees in one full turn
    localparam logic [ANG_W-1:0] DEG_PER_TURN = 9'd360;

    // Register reset values
    localparam logic [STEPS_W-1:0] STEPS_RESET = 16'd800;
    localparam logic [TOL_W-1:0]   TOL_RESET   = 8'd2;

    // Register indexes
    localparam logic REG_STEPS = 1'b0;
    localparam logic REG_TOL   = 1'b1;

    // Drive command codes
    localparam logic [1:0] DRIVE_HALT  = 2'd0;
    localparam logic [1:0] DRIVE_LEFT  = 2'd1;
    localparam logic [1:0] DRIVE_RIGHT = 2'd2;

    // Divider run lengths
    localparam logic [CNT_W-1:0] MOD_BITS = 6'd32;
    localparam logic [CNT_W-1:0] ANG_BITS = 6'd9;

    // Configuration seen by the datapath
    typedef struct packed {
        logic [STEPS_W-1:0] steps_per_turn;
        logic [TOL_W-1:0]   angle_tolerance;
    } t_cfg;

    // Request to the serial divider
    typedef struct packed {
        logic               start;
        logic [STEPS_W-1:0] init_rem;
        logic [POS_W-1:0]   dividend;
        logic [CNT_W-1:0]   nbits;
    } t_div_req;

    // Status from the serial divider
    typedef struct packed {
        logic               busy;
        logic               done;
        logic [STEPS_W-1:0] rem;
        logic [ANG_W-1:0]   quot;
    } t_div_rsp;

endpackage

>>> sv/esas_if.sv
// Input item channel.
interface esas_in_if;
    import esas_pkg::*;
    logic             valid;
    logic             ready;
    logic             kind;
    logic             phase_a;
    logic             phase_b;
    logic [ANG_W-1:0] target_angle;

    modport source (output valid, kind, phase_a, phase_b, target_angle, input ready);
    modport sink   (input valid, kind, phase_a, phase_b, target_angle, output ready);
endinterface

// Result item channel.
interface esas_out_if;
    import esas_pkg::*;
    logic                    valid;
    logic                    ready;
    logic signed [POS_W-1:0] step_position;
    logic [ANG_W-1:0]        wheel_angle;
    logic [1:0]              drive;
    logic                    on_target;

    modport source (output valid, step_position, wheel_angle, drive, on_target,
                    input ready);
    modport sink   (input valid, step_position, wheel_angle, drive, on_target,
                    output ready);
endinterface

>>> sv/esas_regs.sv
module esas_regs
    import esas_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    logic [STEPS_W-1:0] r_steps;
    logic [TOL_W-1:0]   r_tol;
    logic               wr_en;
    logic               reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_sel = paddr[2];

    // Register writes in the access phase.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_steps <= STEPS_RESET;
            r_tol   <= TOL_RESET;
        end else if (wr_en) begin
            case (reg_sel)
                REG_STEPS: r_steps <= pwdata[STEPS_W-1:0];
                REG_TOL:   r_tol   <= pwdata[TOL_W-1:0];
                default:   r_tol   <= r_tol;
            endcase
        end
    end

    // Read back.
    always_comb begin
        case (reg_sel)
            REG_STEPS: prdata = {{(32-STEPS_W){1'b0}}, r_steps};
            REG_TOL:   prdata = {{(32-TOL_W){1'b0}}, r_tol};
            default:   prdata = '0;
        endcase
    end

    assign o_cfg.steps_per_turn  = r_steps;
    assign o_cfg.angle_tolerance = r_tol;

endmodule

>>> sv/esas_div.sv
module esas_div
    import esas_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_div_req           i_req,
    input  logic [STEPS_W-1:0] i_divisor,
    output t_div_rsp           o_rsp
);

    logic [STEPS_W-1:0] r_rem;
    logic [POS_W-1:0]   r_sh;
    logic [ANG_W-1:0]   r_q;
    logic [CNT_W-1:0]   r_cnt;
    logic               r_busy;
    logic               r_done;
    logic [STEPS_W:0]   trial;
    logic [STEPS_W:0]   diff;
    logic               fits;

    // One restoring step: bring down the next dividend bit and try the divisor.
    assign trial = {r_rem, r_sh[POS_W-1]};
    assign diff  = trial - {1'b0, i_divisor};
    assign fits  = trial >= {1'b0, i_divisor};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_req.nbits;
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath shift registers carry no reset.
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= i_req.init_rem;
            r_sh  <= i_req.dividend;
            r_q   <= '0;
        end else if (r_busy) begin
            r_rem <= fits ? diff[STEPS_W-1:0] : trial[STEPS_W-1:0];
            r_sh  <= {r_sh[POS_W-2:0], 1'b0};
            r_q   <= {r_q[ANG_W-2:0], fits};
        end
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_done;
    assign o_rsp.rem  = r_rem;
    assign o_rsp.quot = r_q;

endmodule

>>> sv/encoder_steering_angle_servo_top.sv
// Channel   Direction  Transfer when           Payload
// i_item    in         valid && ready          kind, phase_a, phase_b, target_angle
// o_res     out        valid && ready          step_position, wheel_angle, drive, on_target
// APB       in         psel, penable, pwrite   steps_per_turn @0x0, angle_tolerance @0x4
//
// The result of an item is worked out after its transfer in: one serial divider,
// one bit a cycle, runs 32 steps for the position remainder and then 9 steps for
// the angle quotient. The input is ready again only once the result stands in the
// output register, so a new item is taken only when the last one is through.
// With steps_per_turn zero the divider is skipped and the angle is taken as zero.
// A finished result waits while the output register is still full, and the input
// stalls until it moves on. Reset is synchronous, active low, and clears position,
// phase and handshakes.
`include "encoder_steering_angle_servo_top_assert.svh"

module encoder_steering_angle_servo_top
    import esas_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    esas_in_if.sink           i_item,
    esas_out_if.source        o_res,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MOD_GO,
        S_MOD,
        S_ANG_GO,
        S_ANG,
        S_FIN
    } t_state;

    t_state                  r_state;
    logic [POS_W-1:0]        r_pos;
    logic                    r_last_a;
    logic [ANG_W-1:0]        r_tgt;
    logic [PROD_W-1:0]       r_prod;
    logic [ANG_W-1:0]        r_ang;
    logic                    r_out_valid;
    logic signed [POS_W-1:0] r_o_pos;
    logic [ANG_W-1:0]        r_o_ang;
    logic [1:0]              r_o_drive;
    logic                    r_o_hit;

    t_cfg                    cfg;
    t_div_req                div_req;
    t_div_rsp                div_rsp;
    logic [POS_W-1:0]        n_pos;
    logic [POS_W-1:0]        mag;
    logic                    in_xfer;
    logic                    out_free;
    logic [ANG_W:0]          ang_ext;
    logic [ANG_W:0]          tgt_ext;
    logic [ANG_W:0]          tol_ext;
    logic                    hit;
    logic [1:0]              drive;

    esas_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    esas_div u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (div_req),
        .i_divisor (cfg.steps_per_turn),
        .o_rsp     (div_rsp)
    );

    assign i_item.ready = (r_state == S_IDLE);
    assign in_xfer      = i_item.valid && i_item.ready;
    assign out_free     = !r_out_valid || o_res.ready;

    // Position after this item: a zero command clears it, a change of A steps it.
    always_comb begin
        n_pos = r_pos;
        if (i_item.kind) begin
            n_pos = '0;
        end else if (i_item.phase_a != r_last_a) begin
            n_pos = (i_item.phase_a == i_item.phase_b) ? r_pos + POS_W'(1) : r_pos - POS_W'(1);
        end
    end

    // Magnitude of the position; the most negative value keeps its pattern.
    assign mag = r_pos[POS_W-1] ? (~r_pos + POS_W'(1)) : r_pos;

    // Divider requests: remainder of the magnitude, then quotient of the product.
    always_comb begin
        div_req = '0;
        if (r_state == S_MOD_GO) begin
            div_req.start    = 1'b1;
            div_req.init_rem = '0;
            div_req.dividend = mag;
            div_req.nbits    = MOD_BITS;
        end else if (r_state == S_ANG_GO) begin
            div_req.start    = 1'b1;
            div_req.init_rem = r_prod[PROD_W-1:ANG_W];
            div_req.dividend = {r_prod[ANG_W-1:0], {(POS_W-ANG_W){1'b0}}};
            div_req.nbits    = ANG_BITS;
        end
    end

    // On-target band and drive command.
    assign ang_ext = {1'b0, r_ang};
    assign tgt_ext = {1'b0, r_tgt};
    assign tol_ext = {{(ANG_W+1-TOL_W){1'b0}}, cfg.angle_tolerance};
    assign hit     = (ang_ext + tol_ext >= tgt_ext) && (ang_ext <= tgt_ext + tol_ext);
    always_comb begin
        if (hit) begin
            drive = DRIVE_HALT;
        end else if (r_ang < r_tgt) begin
            drive = DRIVE_LEFT;
        end else begin
            drive = DRIVE_RIGHT;
        end
    end

    // Sequencer, position state and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pos       <= '0;
            r_last_a    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // In the finishing state the output register is refilled instead.
            if (r_out_valid && o_res.ready && r_state != S_FIN) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_xfer) begin
                        r_pos <= n_pos;
                        r_tgt <= i_item.target_angle;
                        if (!i_item.kind) begin
                            r_last_a <= i_item.phase_a;
                        end
                        if (cfg.steps_per_turn == '0) begin
                            r_ang   <= '0;
                            r_state <= S_FIN;
                        end else begin
                            r_state <= S_MOD_GO;
                        end
                    end
                end
                S_MOD_GO: r_state <= S_MOD;
                S_MOD: begin
                    if (div_rsp.done) begin
                        r_prod  <= PROD_W'(div_rsp.rem) * PROD_W'(DEG_PER_TURN);
                        r_state <= S_ANG_GO;
                    end
                end
                S_ANG_GO: r_state <= S_ANG;
                S_ANG: begin
                    if (div_rsp.done) begin
                        r_ang   <= div_rsp.quot;
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_o_pos     <= r_pos;
                        r_o_ang     <= r_ang;
                        r_o_drive   <= drive;
                        r_o_hit     <= hit;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.step_position = r_o_pos;
    assign o_res.wheel_angle   = r_o_ang;
    assign o_res.drive         = r_o_drive;
    assign o_res.on_target     = r_o_hit;

    // The divider only finishes while the sequencer waits for it.
    `ESAS_ASSERT_SAME(a_div_done_waited, i_clk, i_rst_n, div_rsp.done, (r_state == S_MOD || r_state == S_ANG))
    // A transfer in always leaves the idle state.
    `ESAS_ASSERT_NEXT(a_xfer_leaves_idle, i_clk, i_rst_n, in_xfer, (r_state != S_IDLE))
    // A result on target is always a halt command.
    `ESAS_ASSERT_SAME(a_halt_on_target, i_clk, i_rst_n, r_out_valid, (r_o_hit == (r_o_drive == DRIVE_HALT)))

endmodule
